### src/gtg_pkg.sv
// Shared constants, command and status types, and the CORDIC arctangent table.
package gtg_pkg;

  localparam int          CORDIC_STEPS_DEF = 16;
  localparam int          ATAN_DEPTH       = 24;
  localparam int          CFG_INDEX_W      = 3;
  localparam logic [2:0]  REG_GOAL_X       = 3'd0;
  localparam logic [2:0]  REG_GOAL_Y       = 3'd1;
  localparam logic [2:0]  REG_SPEED_LIMIT  = 3'd2;
  localparam logic [2:0]  REG_STOP_RADIUS  = 3'd3;
  localparam logic        ACT_ODOM         = 1'b0;
  localparam logic        ACT_TICK         = 1'b1;
  localparam logic signed [34:0] PI_Q30    = 35'sd3373259426;
  localparam logic signed [15:0] PI_Q12    = 16'sd12868;
  localparam logic [29:0] INV_GAIN_Q30     = 30'd652032874;
  localparam int          NORM_BIT         = 56;

  typedef struct packed {
    logic load;
    logic prod;
    logic sums;
    logic norm_step;
    logic init;
    logic iter;
    logic mult;
    logic fin;
  } gtg_cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
    logic iter_last;
    logic out_busy;
  } gtg_status_t;

  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    atan_q30 = 35'sd843314857;
      5'd1:    atan_q30 = 35'sd497837829;
      5'd2:    atan_q30 = 35'sd263043837;
      5'd3:    atan_q30 = 35'sd133525159;
      5'd4:    atan_q30 = 35'sd67021687;
      5'd5:    atan_q30 = 35'sd33543516;
      5'd6:    atan_q30 = 35'sd16775851;
      5'd7:    atan_q30 = 35'sd8388437;
      5'd8:    atan_q30 = 35'sd4194283;
      5'd9:    atan_q30 = 35'sd2097149;
      5'd10:   atan_q30 = 35'sd1048576;
      5'd11:   atan_q30 = 35'sd524288;
      5'd12:   atan_q30 = 35'sd262144;
      5'd13:   atan_q30 = 35'sd131072;
      5'd14:   atan_q30 = 35'sd65536;
      5'd15:   atan_q30 = 35'sd32768;
      5'd16:   atan_q30 = 35'sd16384;
      5'd17:   atan_q30 = 35'sd8192;
      5'd18:   atan_q30 = 35'sd4096;
      5'd19:   atan_q30 = 35'sd2048;
      5'd20:   atan_q30 = 35'sd1024;
      5'd21:   atan_q30 = 35'sd512;
      5'd22:   atan_q30 = 35'sd256;
      5'd23:   atan_q30 = 35'sd128;
      default: atan_q30 = 35'sd0;
    endcase
  endfunction

endpackage

### src/gtg_if.sv
// Input and output channel interfaces.
interface gtg_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [14:0] quat_x;
  logic signed [14:0] quat_y;
  logic signed [14:0] quat_z;
  logic signed [14:0] quat_w;
  modport source (output valid, action, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, action, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface

interface gtg_out_if;
  logic               valid;
  logic               ready;
  logic [22:0]        linear_speed;
  logic signed [15:0] angular_rate;
  modport source (output valid, linear_speed, angular_rate, input ready);
  modport sink (input valid, linear_speed, angular_rate, output ready);
endinterface

### src/gtg_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module gtg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtg_pkg::gtg_status_t status,
  output gtg_pkg::gtg_cmd_t    cmd
);
  import gtg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_SUMS, S_NORM, S_INIT, S_ITER, S_MULT, S_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && !status.out_busy;

  always_comb begin
    cmd           = '0;
    cmd.load      = in_ready && in_valid;
    cmd.prod      = (state == S_PROD);
    cmd.sums      = (state == S_SUMS);
    cmd.norm_step = (state == S_NORM) && !status.special && !status.norm_done;
    cmd.init      = (state == S_INIT);
    cmd.iter      = (state == S_ITER);
    cmd.mult      = (state == S_MULT);
    cmd.fin       = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_ready && in_valid) state <= S_PROD;
        S_PROD: state <= S_SUMS;
        S_SUMS: state <= S_NORM;
        S_NORM: begin
          if (status.special) state <= S_FIN;
          else if (status.norm_done) state <= S_INIT;
        end
        S_INIT: state <= S_ITER;
        S_ITER: if (status.iter_last) state <= S_MULT;
        S_MULT: state <= S_FIN;
        S_FIN:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### src/gtg_dp.sv
// Datapath: configuration, stored pose, shared vectoring CORDIC and output register.
module gtg_dp #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gtg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  gtg_in_if.sink                            in_ch,
  gtg_out_if.source                         out_ch,
  input  gtg_pkg::gtg_cmd_t                 cmd,
  output gtg_pkg::gtg_status_t              status
);
  import gtg_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;

  logic signed [31:0] goal_x, goal_y;
  logic [22:0]        speed_limit;
  logic [16:0]        stop_radius;
  logic signed [31:0] stored_x, stored_y;
  logic signed [15:0] stored_yaw;

  logic               act;
  logic signed [14:0] qx, qy, qz, qw;
  logic signed [32:0] dx, dy;
  logic signed [29:0] p_xx, p_yy, p_zz, p_ww, p_xy, p_wz, p_xz, p_wy;
  logic signed [31:0] pos_x_r, pos_y_r;

  logic [56:0]        va, vb, vm;
  logic               sx, sy, special;
  logic [5:0]         s;
  logic signed [60:0] cx_r, cy_r;
  logic signed [34:0] z;
  logic [4:0]         i;
  logic [63:0]        prod;
  logic signed [15:0] ang;
  logic               out_valid;
  logic [22:0]        out_speed;
  logic signed [15:0] out_rate;

  logic signed [33:0] num, den, dsum, gv, ga, cx, cy;
  logic [33:0]        ax, ay;
  logic signed [60:0] tx, ty, xc;
  logic signed [34:0] rnd;
  logic [64:0]        mag_sum, mag_full;
  logic [35:0]        mag;
  logic signed [15:0] ang_fin, ang_abs;
  logic signed [16:0] rate;

  assign num  = 34'(2) * (34'(p_xy) + 34'(p_wz));
  assign den  = 34'(p_ww) + 34'(p_xx) - 34'(p_yy) - 34'(p_zz);
  assign dsum = 34'(p_ww) + 34'(p_xx) + 34'(p_yy) + 34'(p_zz);
  assign gv   = 34'(2) * (34'(p_xz) - 34'(p_wy));
  assign ga   = (gv < 0) ? -gv : gv;
  assign cx   = (act == ACT_TICK) ? 34'(dx) : den;
  assign cy   = (act == ACT_TICK) ? 34'(dy) : num;
  assign ax   = (cx < 0) ? 34'(-cx) : 34'(cx);
  assign ay   = (cy < 0) ? 34'(-cy) : 34'(cy);

  assign tx = cy_r >>> i;
  assign ty = cx_r >>> i;
  assign xc = (cx_r < 0) ? '0 : cx_r;

  always_comb begin
    if (z >= 0) rnd = (z + 35'sd131072) >>> 18;
    else rnd = -((-z + 35'sd131072) >>> 18);
  end

  assign mag_sum  = {1'b0, prod} + (65'd1 << (7'(s) + 7'd3));
  assign mag_full = mag_sum >> (7'(s) + 7'd4);
  assign mag      = special ? '0 : mag_full[35:0];
  assign ang_fin  = special ? '0 : ang;
  assign ang_abs  = (ang_fin < 0) ? -ang_fin : ang_fin;
  assign rate     = 17'(ang_abs) - 17'(stored_yaw);

  assign status.special   = special;
  assign status.norm_done = vm[NORM_BIT];
  assign status.iter_last = (i == 5'(STEPS - 1));
  assign status.out_busy  = out_valid;

  assign out_ch.valid        = out_valid;
  assign out_ch.linear_speed = out_speed;
  assign out_ch.angular_rate = out_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x      <= 32'sd655360;
      goal_y      <= 32'sd327680;
      speed_limit <= 23'd98304;
      stop_radius <= 17'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:      goal_x      <= cfg_data;
        REG_GOAL_Y:      goal_y      <= cfg_data;
        REG_SPEED_LIMIT: speed_limit <= cfg_data[22:0];
        REG_STOP_RADIUS: stop_radius <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_x   <= '0;
      stored_y   <= '0;
      stored_yaw <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cmd.sums && act == ACT_ODOM) begin
        stored_x <= pos_x_r;
        stored_y <= pos_y_r;
      end
      if (cmd.fin) begin
        if (act == ACT_ODOM) begin
          stored_yaw <= ang_fin;
        end else begin
          out_valid <= 1'b1;
          out_rate  <= rate[15:0];
          if (mag > 36'(speed_limit)) out_speed <= speed_limit;
          else if (mag < 36'(stop_radius)) out_speed <= '0;
          else out_speed <= mag[22:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act     <= in_ch.action;
      pos_x_r <= in_ch.pos_x;
      pos_y_r <= in_ch.pos_y;
      qx      <= in_ch.quat_x;
      qy      <= in_ch.quat_y;
      qz      <= in_ch.quat_z;
      qw      <= in_ch.quat_w;
      dx      <= 33'(goal_x) - 33'(stored_x);
      dy      <= 33'(goal_y) - 33'(stored_y);
    end
    if (cmd.prod) begin
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_ww <= qw * qw;
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      p_xz <= qx * qz;
      p_wy <= qw * qy;
    end
    if (cmd.sums) begin
      va      <= 57'(ax);
      vb      <= 57'(ay);
      vm      <= 57'((ax > ay) ? ax : ay);
      sx      <= (cx < 0);
      sy      <= (cy < 0);
      s       <= '0;
      special <= ((cx == 0) && (cy == 0)) || ((act == ACT_ODOM) && (ga >= dsum));
    end
    if (cmd.norm_step) begin
      if (vm[56:41] == '0) begin
        va <= va << 16; vb <= vb << 16; vm <= vm << 16; s <= s + 6'd16;
      end else if (vm[56:53] == '0) begin
        va <= va << 4; vb <= vb << 4; vm <= vm << 4; s <= s + 6'd4;
      end else begin
        va <= va << 1; vb <= vb << 1; vm <= vm << 1; s <= s + 6'd1;
      end
    end
    if (cmd.init) begin
      cx_r <= 61'(va);
      cy_r <= (sx ^ sy) ? -61'(vb) : 61'(vb);
      z    <= sx ? (sy ? -PI_Q30 : PI_Q30) : '0;
      i    <= '0;
    end
    if (cmd.iter) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + tx; cy_r <= cy_r - ty; z <= z + atan_q30(i);
      end else begin
        cx_r <= cx_r - tx; cy_r <= cy_r + ty; z <= z - atan_q30(i);
      end
      i <= i + 5'd1;
    end
    if (cmd.mult) begin
      prod <= {29'd0, xc[60:26]} * {34'd0, INV_GAIN_Q30};
      if (rnd > 35'(PI_Q12)) ang <= PI_Q12;
      else if (rnd < -35'(PI_Q12)) ang <= -PI_Q12;
      else ang <= rnd[15:0];
    end
  end
endmodule

### src/go_to_goal_velocity_command.sv
// Top level of the go-to-goal velocity command block.
//   channel  dir  payload
//   in_ch    in   action, pos_x, pos_y, quat_x..quat_w
//   out_ch   out  linear_speed, angular_rate (ticks only)
//   cfg      in   cfg_we, cfg_index, cfg_data
// One transaction at a time; each goes from acceptance through the product and sum states,
// a normalization that shifts the vector until its top bit is set, the CORDIC iteration
// loop, then the multiply and finish states. A zero vector or gimbal lock skips the CORDIC.
// Reset is synchronous and active high; it restores the goal defaults and clears the pose.
// A new transaction is taken only when the result register is empty.
module go_to_goal_velocity_command #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gtg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  gtg_in_if.sink                          in_ch,
  gtg_out_if.source                       out_ch
);
  import gtg_pkg::*;

  gtg_cmd_t    cmd;
  gtg_status_t status;

  gtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gtg_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .status    (status)
  );
endmodule
